/* design/cfss_pkg.sv */
// ----------------------------------------------------------------------------
// cfss_pkg: shared types and helpers of the case folding substring search
// Word formats, operation codes, register indexes and the case fold.
// ----------------------------------------------------------------------------
`default_nettype none

package cfss_pkg;

  localparam int unsigned PAT_MAX_DEF = 128;
  localparam int unsigned QDEPTH      = 2;
  localparam logic [7:0]  LINE_END    = 8'd13;

  typedef enum logic [1:0] {
    FUNC_TEXT    = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_RESTART = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_EXACT_CASE   = 2'd0,
    REG_REVERSE      = 2'd1,
    REG_REPEAT_COUNT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic        match;
    logic [31:0] match_start;
    logic [31:0] match_end;
    logic [15:0] match_ordinal;
    logic        target_reached;
    logic        no_pattern;
    logic        pattern_overflow;
  } out_word_t;

  typedef struct packed {
    logic        exact_case;
    logic        reverse;
    logic [15:0] repeat_count;
  } cfg_t;

  typedef struct packed {
    func_e      op;
    logic [7:0] ch;
  } op_word_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
    logic [7:0] r;
    r = c;
    if (!exact && c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/cfss_front.sv */
// ----------------------------------------------------------------------------
// cfss_front: input decode
// Take words from the input channel, decode the function and fold text.
// ----------------------------------------------------------------------------
`default_nettype none

module cfss_front (
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cfss_pkg::in_word_t in_word_i,
  input  wire cfss_pkg::cfg_t    cfg_i,
  input  wire logic              q_ready_i,
  output logic                   q_push_o,
  output cfss_pkg::op_word_t     q_word_o
);
  import cfss_pkg::*;

  func_e op;

  assign op         = func_e'(in_word_i.func);
  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i;

  always_comb begin
    q_word_o.op = op;
    case (op)
      FUNC_TEXT: q_word_o.ch = fold(in_word_i.char_code, cfg_i.exact_case);
      default:   q_word_o.ch = in_word_i.char_code;
    endcase
  end

endmodule

`default_nettype wire

/* design/cfss_queue.sv */
// ----------------------------------------------------------------------------
// cfss_queue: decoupling queue
// Short queue of decoded words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cfss_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire cfss_pkg::op_word_t push_word_i,
  output logic                    ready_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output cfss_pkg::op_word_t      pop_word_o
);
  import cfss_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  op_word_t         mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o    = count_q < CNT_W'(QDEPTH);
  assign valid_o    = count_q != '0;
  assign pop_word_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("push not counted");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> !do_pop)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

/* design/cfss_back.sv */
// ----------------------------------------------------------------------------
// cfss_back: search engine
// Shift-and partial match lanes, pattern store, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfss_back #(
  parameter int unsigned PAT_MAX = cfss_pkg::PAT_MAX_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfss_pkg::cfg_t     cfg_i,
  input  wire logic               q_valid_i,
  input  wire cfss_pkg::op_word_t q_word_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cfss_pkg::out_word_t     out_word_o
);
  import cfss_pkg::*;

  localparam int unsigned LEN_W = $clog2(PAT_MAX + 1);

  logic [7:0]         store_q  [PAT_MAX];
  logic [7:0]         rstore_q [PAT_MAX];
  logic [LEN_W-1:0]   len_q, len_d;
  logic [PAT_MAX-1:0] partial_q, partial_d;
  logic [PAT_MAX-1:0] pnext, last_mask;
  logic [31:0]        pos_q, pos_d, pos_inc;
  logic [15:0]        found_q, found_d, found_inc;
  logic               done_q, done_d;
  logic               out_valid_q;
  out_word_t          out_q, out_d;
  logic               hit, append_ok;

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    for (int k = 0; k < PAT_MAX; k++) begin
      logic prev, same_fwd, same_rev;
      prev     = (k == 0) ? 1'b1 : partial_q[(k == 0) ? 0 : k - 1];
      same_fwd = fold(store_q[k], cfg_i.exact_case) == q_word_i.ch;
      same_rev = fold(rstore_q[k], cfg_i.exact_case) == q_word_i.ch;
      pnext[k]     = prev && (cfg_i.reverse ? same_rev : same_fwd);
      last_mask[k] = len_q == LEN_W'(k + 1);
    end
  end

  assign hit       = |(pnext & last_mask);
  assign pos_inc   = (pos_q == '1) ? pos_q : pos_q + 32'd1;
  assign found_inc = (found_q == '1) ? found_q : found_q + 16'd1;
  assign append_ok = len_q < LEN_W'(PAT_MAX);

  always_comb begin
    len_d     = len_q;
    partial_d = '0;
    pos_d     = pos_q;
    found_d   = found_q;
    done_d    = done_q;
    out_d     = '0;
    case (q_word_i.op)
      FUNC_TEXT: begin
        pos_d = pos_inc;
        if (len_q == '0) begin
          out_d.no_pattern = 1'b1;
        end else if (!done_q) begin
          if (hit) begin
            found_d           = found_inc;
            done_d            = found_inc >= cfg_i.repeat_count;
            out_d.match       = 1'b1;
            out_d.match_end   = pos_inc;
            out_d.match_start = pos_inc - 32'(len_q);
          end else begin
            partial_d = pnext;
          end
        end else begin
          partial_d = partial_q;
        end
      end
      FUNC_APPEND: begin
        if (append_ok) begin
          len_d = len_q + 1'b1;
        end else begin
          out_d.pattern_overflow = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        len_d = '0;
      end
      FUNC_RESTART: begin
        pos_d   = '0;
        found_d = '0;
        done_d  = 1'b0;
      end
      default: begin
        partial_d = '0;
      end
    endcase
    out_d.match_ordinal  = found_d;
    out_d.target_reached = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      partial_q   <= '0;
      pos_q       <= '0;
      found_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        len_q       <= len_d;
        partial_q   <= partial_d;
        pos_q       <= pos_d;
        found_q     <= found_d;
        done_q      <= done_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
    if (q_pop_o && q_word_i.op == FUNC_APPEND && append_ok) begin
      rstore_q[0] <= q_word_i.ch;
      for (int k = 1; k < PAT_MAX; k++) begin
        rstore_q[k] <= rstore_q[k-1];
      end
      for (int k = 0; k < PAT_MAX; k++) begin
        if (len_q == LEN_W'(k)) begin
          store_q[k] <= q_word_i.ch;
        end
      end
    end
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(PAT_MAX))
    else $error("pattern length beyond store");

  a_edit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_word_i.op != FUNC_TEXT |=> partial_q == '0)
    else $error("partial matches kept across pattern edit or restart");

  a_match_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.match |-> out_q.match_ordinal != '0 && !out_q.no_pattern)
    else $error("match without ordinal");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && done_q && q_word_i.op != FUNC_RESTART |=> done_q)
    else $error("search end dropped without restart");

endmodule

`default_nettype wire

/* design/case_folding_substring_search_top.sv */
// ----------------------------------------------------------------------------
// case_folding_substring_search_top: streaming substring search
// A taken input word is written into the queue, then popped by the search engine into its result register.
// Throughput: one word per cycle while the output is not stalled, set by the shift-and lane update.
// A two-entry queue parts the decode front from the search engine.
// Reset clears lengths, counters, partial matches, the result valid flag and the configuration at once;
// the pattern store holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module case_folding_substring_search_top #(
  parameter int unsigned PAT_MAX = cfss_pkg::PAT_MAX_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire cfss_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output cfss_pkg::out_word_t      out_word_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);
  import cfss_pkg::*;

  cfg_t     cfg_q;
  op_word_t push_word, pop_word;
  logic     q_ready, q_push, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.exact_case   <= 1'b0;
      cfg_q.reverse      <= 1'b0;
      cfg_q.repeat_count <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_EXACT_CASE:   cfg_q.exact_case   <= cfg_data_i[0];
        REG_REVERSE:      cfg_q.reverse      <= cfg_data_i[0];
        REG_REPEAT_COUNT: cfg_q.repeat_count <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  cfss_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg_q),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_word_o   (push_word)
  );

  cfss_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (push_word),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_word_o  (pop_word)
  );

  cfss_back #(
    .PAT_MAX (PAT_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_word_i    (pop_word),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
